FILE: rtl/core/rtc_pkg.sv
package rtc_pkg;

  // Field widths
  localparam int SEC_W    = 6;
  localparam int MIN_W    = 6;
  localparam int HOUR_W   = 5;
  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 16;
  localparam int WDAY_W   = 3;
  localparam int LIMIT_W  = 20;
  localparam int UPTIME_W = 32;

  // Operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Rollover limits
  localparam logic [SEC_W-1:0]   SEC_MAX   = 6'd59;
  localparam logic [MIN_W-1:0]   MIN_MAX   = 6'd59;
  localparam logic [HOUR_W-1:0]  HOUR_MAX  = 5'd23;
  localparam logic [WDAY_W-1:0]  WDAY_MAX  = 3'd6;
  localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;

  localparam logic [LIMIT_W-1:0] VALID_LIMIT_RESET = 20'd3600;

  typedef struct packed {
    logic [SEC_W-1:0]    cur_second;
    logic [MIN_W-1:0]    cur_minute;
    logic [HOUR_W-1:0]   cur_hour;
    logic [DAY_W-1:0]    cur_day;
    logic [MONTH_W-1:0]  cur_month;
    logic [YEAR_W-1:0]   cur_year;
    logic [WDAY_W-1:0]   cur_weekday;
    logic                time_ok;
    logic [UPTIME_W-1:0] uptime_seconds;
  } result_t;

  // Days in a month; zero outside 1 to 12, no leap years
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/core/rtc_in_if.sv
interface rtc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [rtc_pkg::SEC_W-1:0]   new_second;
  logic [rtc_pkg::MIN_W-1:0]   new_minute;
  logic [rtc_pkg::HOUR_W-1:0]  new_hour;
  logic [rtc_pkg::DAY_W-1:0]   new_day;
  logic [rtc_pkg::MONTH_W-1:0] new_month;
  logic [rtc_pkg::YEAR_W-1:0]  new_year;
  logic [rtc_pkg::WDAY_W-1:0]  new_weekday;

  modport source (
    output valid, operation, new_second, new_minute, new_hour, new_day,
           new_month, new_year, new_weekday,
    input  ready
  );
  modport sink (
    input  valid, operation, new_second, new_minute, new_hour, new_day,
           new_month, new_year, new_weekday,
    output ready
  );
endinterface

FILE: rtl/core/rtc_out_if.sv
interface rtc_out_if;
  logic                         valid;
  logic                         ready;
  logic [rtc_pkg::SEC_W-1:0]    cur_second;
  logic [rtc_pkg::MIN_W-1:0]    cur_minute;
  logic [rtc_pkg::HOUR_W-1:0]   cur_hour;
  logic [rtc_pkg::DAY_W-1:0]    cur_day;
  logic [rtc_pkg::MONTH_W-1:0]  cur_month;
  logic [rtc_pkg::YEAR_W-1:0]   cur_year;
  logic [rtc_pkg::WDAY_W-1:0]   cur_weekday;
  logic                         time_ok;
  logic [rtc_pkg::UPTIME_W-1:0] uptime_seconds;

  modport source (
    output valid, cur_second, cur_minute, cur_hour, cur_day, cur_month,
           cur_year, cur_weekday, time_ok, uptime_seconds,
    input  ready
  );
  modport sink (
    input  valid, cur_second, cur_minute, cur_hour, cur_day, cur_month,
           cur_year, cur_weekday, time_ok, uptime_seconds,
    output ready
  );
endinterface

FILE: rtl/core/calendar_clock_with_validity_timeout_core.sv
// A result is registered in the output head entry, or in the skid entry behind a stalled head.
// Throughput: one item per cycle while the skid entry is empty; the calendar update
// is a single pass of short compare and increment logic between the state and result registers.
// A two-entry output buffer keeps input accepting while one result is stalled.
// Reset (synchronous, active high): calendar, valid flag and uptime clear,
// the limit returns to 3600 and the age counter starts at 3600.
module calendar_clock_with_validity_timeout_core (
  input  logic                          clk,
  input  logic                          rst,
  rtc_in_if.sink                        req,
  rtc_out_if.source                     rsp,
  input  logic                          cfg_wr_en,
  input  logic [rtc_pkg::LIMIT_W-1:0]   cfg_wr_data
);

  // Calendar state
  logic [rtc_pkg::SEC_W-1:0]    sec_reg;
  logic [rtc_pkg::MIN_W-1:0]    min_reg;
  logic [rtc_pkg::HOUR_W-1:0]   hour_reg;
  logic [rtc_pkg::DAY_W-1:0]    day_reg;
  logic [rtc_pkg::MONTH_W-1:0]  month_reg;
  logic [rtc_pkg::YEAR_W-1:0]   year_reg;
  logic [rtc_pkg::WDAY_W-1:0]   weekday_reg;
  logic                         valid_flag;
  logic [rtc_pkg::LIMIT_W-1:0]  age_counter;
  logic [rtc_pkg::UPTIME_W-1:0] uptime_counter;
  logic [rtc_pkg::LIMIT_W-1:0]  valid_limit;

  logic [rtc_pkg::SEC_W-1:0]    sec_reg_next;
  logic [rtc_pkg::MIN_W-1:0]    min_reg_next;
  logic [rtc_pkg::HOUR_W-1:0]   hour_reg_next;
  logic [rtc_pkg::DAY_W-1:0]    day_reg_next;
  logic [rtc_pkg::MONTH_W-1:0]  month_reg_next;
  logic [rtc_pkg::YEAR_W-1:0]   year_reg_next;
  logic [rtc_pkg::WDAY_W-1:0]   weekday_reg_next;
  logic                         valid_flag_next;
  logic [rtc_pkg::LIMIT_W-1:0]  age_counter_next;
  logic [rtc_pkg::UPTIME_W-1:0] uptime_counter_next;

  // Output buffer
  rtc_pkg::result_t out_reg;
  rtc_pkg::result_t skid_reg;
  rtc_pkg::result_t res_next;
  logic             out_valid;
  logic             skid_valid;

  logic in_accept;
  logic out_pop;

  // Carry chain terms
  logic [rtc_pkg::SEC_W:0]     sec_inc;
  logic [rtc_pkg::MIN_W:0]     min_inc;
  logic [rtc_pkg::HOUR_W:0]    hour_inc;
  logic [rtc_pkg::WDAY_W:0]    wday_inc;
  logic [rtc_pkg::DAY_W:0]     day_inc;
  logic [rtc_pkg::DAY_W-1:0]   mlen;
  logic                        sec_roll;
  logic                        min_roll;
  logic                        hour_roll;

  assign req.ready = !skid_valid && !rst;
  assign in_accept = req.valid && req.ready;
  assign out_pop   = out_valid && rsp.ready;

  assign sec_inc  = {1'b0, sec_reg} + 7'd1;
  assign min_inc  = {1'b0, min_reg} + 7'd1;
  assign hour_inc = {1'b0, hour_reg} + 6'd1;
  assign wday_inc = {1'b0, weekday_reg} + 4'd1;
  assign day_inc  = {1'b0, day_reg} + 6'd1;
  assign mlen     = rtc_pkg::month_len(month_reg);

  assign sec_roll  = sec_inc > {1'b0, rtc_pkg::SEC_MAX};
  assign min_roll  = sec_roll && (min_inc > {1'b0, rtc_pkg::MIN_MAX});
  assign hour_roll = min_roll && (hour_inc > {1'b0, rtc_pkg::HOUR_MAX});

  // Compute the state after one item
  always_comb begin
    sec_reg_next        = sec_reg;
    min_reg_next        = min_reg;
    hour_reg_next       = hour_reg;
    day_reg_next        = day_reg;
    month_reg_next      = month_reg;
    year_reg_next       = year_reg;
    weekday_reg_next    = weekday_reg;
    valid_flag_next     = valid_flag;
    age_counter_next    = age_counter;
    uptime_counter_next = uptime_counter;
    if (req.operation == rtc_pkg::OP_LOAD) begin
      sec_reg_next     = req.new_second;
      min_reg_next     = req.new_minute;
      hour_reg_next    = req.new_hour;
      day_reg_next     = req.new_day;
      month_reg_next   = req.new_month;
      year_reg_next    = req.new_year;
      weekday_reg_next = req.new_weekday;
      valid_flag_next  = 1'b1;
      age_counter_next = '0;
    end else begin
      uptime_counter_next = uptime_counter + 32'd1;
      // Age the time, drop validity once the limit is reached
      if (age_counter < valid_limit) begin
        age_counter_next = age_counter + 20'd1;
      end else begin
        valid_flag_next = 1'b0;
      end
      sec_reg_next = sec_roll ? '0 : sec_inc[rtc_pkg::SEC_W-1:0];
      if (sec_roll) begin
        min_reg_next = min_roll ? '0 : min_inc[rtc_pkg::MIN_W-1:0];
      end
      if (min_roll) begin
        hour_reg_next = hour_roll ? '0 : hour_inc[rtc_pkg::HOUR_W-1:0];
      end
      // Advance the weekday, day, month and year at midnight
      if (hour_roll) begin
        weekday_reg_next = (wday_inc > {1'b0, rtc_pkg::WDAY_MAX}) ?
                           '0 : wday_inc[rtc_pkg::WDAY_W-1:0];
        if (mlen == '0) begin
          day_reg_next = day_inc[rtc_pkg::DAY_W-1:0];
        end else if (day_inc > {1'b0, mlen}) begin
          day_reg_next = 5'd1;
          if (month_reg == rtc_pkg::MONTH_MAX) begin
            month_reg_next = 4'd1;
            year_reg_next  = year_reg + 16'd1;
          end else begin
            month_reg_next = month_reg + 4'd1;
          end
        end else begin
          day_reg_next = day_inc[rtc_pkg::DAY_W-1:0];
        end
      end
    end
  end

  always_comb begin
    res_next.cur_second     = sec_reg_next;
    res_next.cur_minute     = min_reg_next;
    res_next.cur_hour       = hour_reg_next;
    res_next.cur_day        = day_reg_next;
    res_next.cur_month      = month_reg_next;
    res_next.cur_year       = year_reg_next;
    res_next.cur_weekday    = weekday_reg_next;
    res_next.time_ok        = valid_flag_next;
    res_next.uptime_seconds = uptime_counter_next;
  end

  // Hold the limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_limit <= rtc_pkg::VALID_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      valid_limit <= cfg_wr_data;
    end
  end

  // Commit the state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      sec_reg        <= '0;
      min_reg        <= '0;
      hour_reg       <= '0;
      day_reg        <= '0;
      month_reg      <= '0;
      year_reg       <= '0;
      weekday_reg    <= '0;
      valid_flag     <= 1'b0;
      age_counter    <= rtc_pkg::VALID_LIMIT_RESET;
      uptime_counter <= '0;
    end else if (in_accept) begin
      sec_reg        <= sec_reg_next;
      min_reg        <= min_reg_next;
      hour_reg       <= hour_reg_next;
      day_reg        <= day_reg_next;
      month_reg      <= month_reg_next;
      year_reg       <= year_reg_next;
      weekday_reg    <= weekday_reg_next;
      valid_flag     <= valid_flag_next;
      age_counter    <= age_counter_next;
      uptime_counter <= uptime_counter_next;
    end
  end

  // Output buffer control: fill the head first, spill to the skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_pop) begin
          skid_valid <= 1'b0;
        end
      end else if (in_accept) begin
        if (out_valid && !out_pop) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output buffer payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_pop) begin
        out_reg <= skid_reg;
      end
    end else if (in_accept) begin
      if (out_valid && !out_pop) begin
        skid_reg <= res_next;
      end else begin
        out_reg <= res_next;
      end
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.cur_second     = out_reg.cur_second;
  assign rsp.cur_minute     = out_reg.cur_minute;
  assign rsp.cur_hour       = out_reg.cur_hour;
  assign rsp.cur_day        = out_reg.cur_day;
  assign rsp.cur_month      = out_reg.cur_month;
  assign rsp.cur_year       = out_reg.cur_year;
  assign rsp.cur_weekday    = out_reg.cur_weekday;
  assign rsp.time_ok        = out_reg.time_ok;
  assign rsp.uptime_seconds = out_reg.uptime_seconds;

  // The skid entry is only used behind a full head entry
  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid without head entry");

  // A load marks the time valid and restarts aging
  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (in_accept && req.operation == rtc_pkg::OP_LOAD) |=>
      (valid_flag && age_counter == '0))
    else $error("load did not set valid flag or clear age");

  // Uptime moves only on an accepted tick
  a_uptime_tick_only: assert property (@(posedge clk) disable iff (rst)
    (!(in_accept && req.operation == rtc_pkg::OP_TICK)) |=> $stable(uptime_counter))
    else $error("uptime changed without a tick");

  // A stalled result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |=> (out_valid && $stable(out_reg)))
    else $error("stalled result changed");

endmodule
